FILE: design/multidim_array_address_generator_top_assert.svh
// Assertion macros for the array address generator checker.
// Used by the checker module only.
`ifndef MULTIDIM_ARRAY_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define MULTIDIM_ARRAY_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define MAAG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MAAG_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

FILE: design/maag_pkg.sv
// Shared types and constants for the array address generator.
// No dependencies.
package maag_pkg;
    localparam int NUM_ARRAYS = 16;
    localparam int MAX_DIMS   = 8;
    localparam int ID_W       = 4;
    localparam int DIM_W      = 3;
    localparam int ROW_W      = ID_W + DIM_W;
    localparam int ENTRIES    = NUM_ARRAYS * MAX_DIMS;

    typedef enum logic [1:0] {
        OP_DEFINE = 2'd0,
        OP_BOUNDS = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNDEF    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
endpackage

FILE: design/maag_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module maag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/multidim_array_address_generator_top.sv
// Top level of the row-major array address generator.
// Depends on maag_pkg and maag_ram.
//
// Usage:
// Input channel (i_valid/o_ready) carries one item: a define header
// (operation 0), one dimension's bounds (operation 1) or one query index
// (operation 2). Output channel (o_valid/i_ready) carries one result for
// each query index marked last: address, query id and status.
// Define and bound items go through a memory read, then an update/write;
// a query index goes through a memory read, partial products and an
// accumulate step, which registers the result of a last index onto o_valid.
// The bound that completes a descriptor adds a backward stride pass and a
// forward constant-term pass, each a read, multiply, write/accumulate per
// dimension, walking the stride memory one entry at a time.
// A result stays in the output register until taken; other items are
// accepted meanwhile, but a last query index waits until the result leaves.
// Reset clears the defined marks, cursors and output valid; the descriptor
// memories need no clearing pass. 64-bit products are formed from 32-bit
// partial products; only the low 64 bits are kept.
module multidim_array_address_generator_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_operation,
    input  logic [3:0]               i_array_id,
    input  logic [31:0]              i_base_address,
    input  logic [15:0]              i_element_size,
    input  logic [3:0]               i_dim_count,
    input  logic signed [15:0]       i_lower_bound,
    input  logic signed [15:0]       i_upper_bound,
    input  logic signed [15:0]       i_index_value,
    input  logic                     i_last_index,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [63:0]       o_address,
    output logic [3:0]               o_query_array_id,
    output logic [1:0]               o_status
);
    import maag_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_BW_RD, S_BW_MUL, S_BW_WR, S_FW_RD, S_FW_MUL,
        S_FW_ACC, S_Q_MUL, S_Q_ACC
    } t_state;

    t_state r_state;
    logic [NUM_ARRAYS-1:0] r_defined;
    logic [DIM_W:0]  r_def_cur;
    logic [7:0]      r_q_cur;
    logic [63:0]     r_q_sum;
    logic [1:0]      r_op;
    logic [ID_W-1:0] r_id;
    logic [31:0]     r_base;
    logic [15:0]     r_esize;
    logic [3:0]      r_dcnt;
    logic [15:0]     r_lo, r_hi, r_idx;
    logic            r_last;
    logic [DIM_W:0]  r_i;
    logic [63:0]     r_s, r_c;
    logic [63:0]     r_prod_lo, r_prod_hi;
    logic            r_q_ok;
    logic [DIM_W:0]  r_q_dims;
    logic            r_ovalid;
    logic [63:0]     r_oaddr;
    logic [3:0]      r_oid;
    logic [1:0]      r_ost;

    // header memory: {dims, elem, base}
    logic            hdr_we;
    logic [ID_W-1:0] hdr_waddr, hdr_raddr;
    logic [51:0]     hdr_wdata, hdr_rdata;
    logic            off_we;
    logic [ID_W-1:0] off_raddr;
    logic [63:0]     off_wdata, off_rdata;
    logic            bnd_we;
    logic [ROW_W-1:0] bnd_waddr, bnd_raddr;
    logic [31:0]     bnd_wdata, bnd_rdata;
    logic            str_we;
    logic [ROW_W-1:0] str_waddr, str_raddr;
    logic [63:0]     str_wdata, str_rdata;

    maag_ram #(.WIDTH(52), .DEPTH(NUM_ARRAYS)) u_hdr (
        .i_clk, .i_we(hdr_we), .i_waddr(hdr_waddr), .i_wdata(hdr_wdata),
        .i_raddr(hdr_raddr), .o_rdata(hdr_rdata));
    maag_ram #(.WIDTH(64), .DEPTH(NUM_ARRAYS)) u_off (
        .i_clk, .i_we(off_we), .i_waddr(r_id), .i_wdata(off_wdata),
        .i_raddr(off_raddr), .o_rdata(off_rdata));
    maag_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_bnd (
        .i_clk, .i_we(bnd_we), .i_waddr(bnd_waddr), .i_wdata(bnd_wdata),
        .i_raddr(bnd_raddr), .o_rdata(bnd_rdata));
    maag_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_str (
        .i_clk, .i_we(str_we), .i_waddr(str_waddr), .i_wdata(str_wdata),
        .i_raddr(str_raddr), .o_rdata(str_rdata));

    logic [3:0]  hdr_dims;
    logic [15:0] hdr_elem;
    logic [31:0] hdr_base;
    logic [63:0] ext_lo, ext_hi, extent;
    logic        in_fire, blocked;

    assign hdr_dims = hdr_rdata[51:48];
    assign hdr_elem = hdr_rdata[47:32];
    assign hdr_base = hdr_rdata[31:0];
    assign ext_lo = {{48{bnd_rdata[15]}}, bnd_rdata[15:0]};
    assign ext_hi = {{48{bnd_rdata[31]}}, bnd_rdata[31:16]};
    assign extent = ext_hi - ext_lo + 64'd1;

    // hold a last query index while a result waits
    assign blocked = r_ovalid && !i_ready && (t_op'(i_operation) == OP_QUERY)
                     && i_last_index;
    assign o_ready = (r_state == S_IDLE) && !blocked;
    assign in_fire = i_valid && o_ready;

    assign hdr_raddr = in_fire ? i_array_id : r_id;
    assign off_raddr = hdr_raddr;
    assign hdr_we    = (r_state == S_EXEC) && (t_op'(r_op) == OP_DEFINE);
    assign hdr_waddr = r_id;
    assign hdr_wdata = {r_dcnt, r_esize, r_base};
    assign bnd_waddr = {r_id, r_def_cur[DIM_W-1:0]};
    assign bnd_wdata = {r_hi, r_lo};
    assign str_waddr = {r_id, r_i[DIM_W-1:0]};
    assign str_wdata = r_s;
    assign str_we    = (r_state == S_BW_WR);
    assign off_we    = (r_state == S_FW_ACC) && (r_i + 1'b1 >= r_q_dims);
    assign off_wdata = r_c - mul_full;

    logic [DIM_W:0] hdr_dims_c;
    always_comb begin
        hdr_dims_c = hdr_dims[DIM_W:0];
        bnd_we = (r_state == S_EXEC) && (t_op'(r_op) == OP_BOUNDS) && r_defined[r_id] == 1'b0
                 && (r_def_cur < hdr_dims_c);
        bnd_raddr = {r_id, r_i[DIM_W-1:0]};
        str_raddr = {r_id, r_i[DIM_W-1:0]};
        if (in_fire) begin
            str_raddr = {i_array_id, r_q_cur[DIM_W-1:0]};
        end
    end

    // multiplier operand: A is the stride or partial, B is the signed index, the extent or the lower bound
    logic [63:0] mul_full;
    assign mul_full = r_prod_lo + {r_prod_hi[31:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_defined <= '0;
            r_def_cur <= '0;
            r_q_cur   <= '0;
            r_q_sum   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= i_operation;
                        r_id    <= i_array_id;
                        r_base  <= i_base_address;
                        r_esize <= i_element_size;
                        r_dcnt  <= (i_dim_count == 4'd0) ? 4'd1 :
                                   (i_dim_count > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : i_dim_count;
                        r_lo    <= i_lower_bound;
                        r_hi    <= i_upper_bound;
                        r_idx   <= i_index_value;
                        r_last  <= i_last_index;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (t_op'(r_op))
                        OP_DEFINE: begin
                            r_defined[r_id] <= 1'b0;
                            r_def_cur <= '0;
                            r_state   <= S_IDLE;
                        end
                        OP_BOUNDS: begin
                            if (bnd_we && (r_def_cur + 1'b1 >= hdr_dims_c)) begin
                                r_def_cur <= '0;
                                r_i       <= hdr_dims_c - 1'b1;
                                r_s       <= {48'd0, hdr_elem};
                                r_c       <= {32'd0, hdr_base};
                                r_q_dims  <= hdr_dims_c;
                                r_state   <= S_BW_RD;
                            end else begin
                                if (bnd_we) begin
                                    r_def_cur <= r_def_cur + 1'b1;
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        OP_QUERY: begin
                            r_q_ok   <= r_defined[r_id];
                            r_q_dims <= hdr_dims_c;
                            if (r_q_cur == 8'd0) begin
                                r_q_sum <= r_defined[r_id] ? off_rdata : 64'd0;
                            end
                            r_prod_lo <= 64'($signed({1'b0, str_rdata[31:0]}) * $signed(r_idx));
                            r_prod_hi <= 64'($signed({1'b0, str_rdata[63:32]}) * $signed(r_idx));
                            r_state   <= S_Q_ACC;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_Q_ACC: begin
                    logic [7:0] cur_n;
                    logic [63:0] sum_n;
                    cur_n = (r_q_cur == 8'd255) ? r_q_cur : r_q_cur + 8'd1;
                    sum_n = r_q_sum;
                    if (r_q_ok && ({4'd0, r_q_cur} < {4'd0, 4'(r_q_dims)})) begin
                        sum_n = r_q_sum + mul_full;
                    end
                    r_state <= S_IDLE;
                    if (r_last) begin
                        r_ovalid <= 1'b1;
                        r_oid    <= r_id;
                        if (!r_q_ok) begin
                            r_ost <= ST_UNDEF; r_oaddr <= '0;
                        end else if (cur_n != 8'(r_q_dims)) begin
                            r_ost <= ST_MISMATCH; r_oaddr <= '0;
                        end else begin
                            r_ost <= ST_OK; r_oaddr <= sum_n;
                        end
                        r_q_cur <= '0;
                        r_q_sum <= '0;
                    end else begin
                        r_q_cur <= cur_n;
                        r_q_sum <= sum_n;
                    end
                end
                S_BW_RD: r_state <= S_BW_MUL;
                S_BW_MUL: begin
                    r_prod_lo <= r_s[31:0] * extent[31:0];
                    r_prod_hi <= 64'(r_s[63:32] * extent[31:0])
                                 + 64'(r_s[31:0] * extent[63:32]);
                    r_state   <= S_BW_WR;
                end
                S_BW_WR: begin
                    r_s <= mul_full;
                    if (r_i == '0) begin
                        r_state <= S_FW_RD;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_BW_RD;
                    end
                end
                S_FW_RD: r_state <= S_FW_MUL;
                S_FW_MUL: begin
                    r_prod_lo <= str_rdata[31:0] * ext_lo[31:0];
                    r_prod_hi <= 64'(str_rdata[63:32] * ext_lo[31:0])
                                 + 64'(str_rdata[31:0] * ext_lo[63:32]);
                    r_state   <= S_FW_ACC;
                end
                S_FW_ACC: begin
                    if (r_i + 1'b1 >= r_q_dims) begin
                        r_defined[r_id] <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FW_RD;
                    end
                    r_c <= r_c - mul_full;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_address        = r_oaddr;
    assign o_query_array_id = r_oid;
    assign o_status         = r_ost;
endmodule

FILE: design/maag_checker.sv
// Port-level checker for the array address generator, with its bind.
// Depends on multidim_array_address_generator_top_assert.svh.
`include "multidim_array_address_generator_top_assert.svh"
module maag_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_address,
    input logic [1:0]  o_status
);
    `MAAG_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_address))
    `MAAG_ASSERT(a_err_zero, i_clk, i_rst_n, o_valid && o_status != 2'd0 |-> o_address == 64'd0)
    `MAAG_ASSERT(a_status_range, i_clk, i_rst_n, o_valid |-> o_status != 2'd3)
    `MAAG_ASSERT(a_busy_after, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)
    `MAAG_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> !o_valid)
endmodule

bind multidim_array_address_generator_top maag_checker u_maag_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_address, .o_status);

FILE: dv/testbench.sv
// Testbench for the row-major array address generator: drives define, bound
// and query transfers, predicts each address result and compares it.
// Depends on maag_pkg and multidim_array_address_generator_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import maag_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        t_op         op;
        logic [3:0]  id;
        logic [31:0] base;
        logic [15:0] esize;
        logic [3:0]  dims;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] idx;
        logic        last;
    } t_item;

    typedef struct {
        logic [63:0] addr;
        logic [3:0]  id;
        logic [1:0]  status;
    } t_addr_result;

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    class t_addr_scoreboard;
        bit           mark[NUM_ARRAYS];
        int           dims[NUM_ARRAYS];
        logic [15:0]  esize[NUM_ARRAYS];
        logic [31:0]  base[NUM_ARRAYS];
        logic [63:0]  offs[NUM_ARRAYS];
        logic [15:0]  lo[ENTRIES];
        logic [15:0]  hi[ENTRIES];
        logic [63:0]  strd[ENTRIES];
        int           dcur;
        int           qcur;
        logic [63:0]  qsum;
        t_addr_result pending_q[$];
        int           errors;

        function void close_descriptor(int id);
            logic [63:0] s;
            logic [63:0] c;
            int r;
            r = id * MAX_DIMS;
            s = {48'd0, esize[id]};
            for (int i = dims[id] - 1; i >= 0; i--) begin
                strd[r + i] = s;
                s = s * (sx16(hi[r + i]) - sx16(lo[r + i]) + 64'd1);
            end
            c = {32'd0, base[id]};
            for (int i = 0; i < dims[id]; i++)
                c = c - strd[r + i] * sx16(lo[r + i]);
            offs[id] = c;
            mark[id] = 1'b1;
        endfunction

        function void note_transfer(t_item it);
            int id;
            int d;
            bit ok;
            t_addr_result res;
            id = it.id;
            case (it.op)
                OP_DEFINE: begin
                    d = it.dims;
                    if (d == 0) d = 1;
                    if (d > MAX_DIMS) d = MAX_DIMS;
                    mark[id] = 1'b0;
                    base[id] = it.base;
                    esize[id] = it.esize;
                    dims[id] = d;
                    dcur = 0;
                end
                OP_BOUNDS: begin
                    if (!mark[id] && dcur < dims[id]) begin
                        lo[id * MAX_DIMS + dcur] = it.lo;
                        hi[id * MAX_DIMS + dcur] = it.hi;
                        dcur++;
                        if (dcur >= dims[id]) begin
                            close_descriptor(id);
                            dcur = 0;
                        end
                    end
                end
                OP_QUERY: begin
                    ok = mark[id];
                    if (qcur == 0) qsum = ok ? offs[id] : 64'd0;
                    if (ok && qcur < dims[id])
                        qsum = qsum + strd[id * MAX_DIMS + qcur] * sx16(it.idx);
                    if (qcur < 255) qcur++;
                    if (it.last) begin
                        res.id = it.id;
                        res.addr = 64'd0;
                        if (!ok) res.status = ST_UNDEF;
                        else if (qcur != dims[id]) res.status = ST_MISMATCH;
                        else begin
                            res.status = ST_OK;
                            res.addr = qsum;
                        end
                        pending_q.push_back(res);
                        qcur = 0;
                        qsum = 64'd0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_addr_result got);
            t_addr_result exp;
            if (pending_q.size() == 0) begin
                $error("unexpected result: address %h id %0d status %0d",
                       got.addr, got.id, got.status);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.addr !== exp.addr) begin
                $error("address expected %h actual %h", exp.addr, got.addr);
                errors++;
            end
            if (got.id !== exp.id) begin
                $error("query_array_id expected %0d actual %0d", exp.id, got.id);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status expected %0d actual %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = 2'd0;
    logic [3:0]  i_array_id = 4'd0;
    logic [31:0] i_base_address = 32'd0;
    logic [15:0] i_element_size = 16'd0;
    logic [3:0]  i_dim_count = 4'd0;
    logic signed [15:0] i_lower_bound = 16'sd0;
    logic signed [15:0] i_upper_bound = 16'sd0;
    logic signed [15:0] i_index_value = 16'sd0;
    logic        i_last_index = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [63:0] o_address;
    logic [3:0]  o_query_array_id;
    logic [1:0]  o_status;

    multidim_array_address_generator_top uut (.*);

    t_addr_scoreboard sb = new();
    int  cycles;
    bit  idle_on;
    bit  hold_req;
    int  sent;
    int  open_id = -1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : result_side
        int gap;
        t_addr_result got;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.addr = o_address;
                got.id = o_query_array_id;
                got.status = o_status;
                sb.check_result(got);
            end
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_ready <= (gap == 0);
            end else if (hold_req) begin
                hold_req = 1'b0;
                gap = 400;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 16);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_item noise_item();
        t_item it;
        it.op = t_op'($urandom_range(0, 3));
        it.id = 4'($urandom);
        it.base = $urandom;
        it.esize = 16'($urandom);
        it.dims = 4'($urandom);
        it.lo = 16'($urandom);
        it.hi = 16'($urandom);
        it.idx = 16'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic send(t_item it);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= it.op;
        i_array_id <= it.id;
        i_base_address <= it.base;
        i_element_size <= it.esize;
        i_dim_count <= it.dims;
        i_lower_bound <= it.lo;
        i_upper_bound <= it.hi;
        i_index_value <= it.idx;
        i_last_index <= it.last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_transfer(it);
        sent++;
    endtask

    task automatic header(int id, int dfield, logic [31:0] b, logic [15:0] es);
        t_item it;
        it = noise_item();
        it.op = OP_DEFINE;
        it.id = 4'(id);
        it.dims = 4'(dfield);
        it.base = b;
        it.esize = es;
        send(it);
        open_id = id;
    endtask

    task automatic bound(logic [15:0] l, logic [15:0] h);
        t_item it;
        it = noise_item();
        it.op = OP_BOUNDS;
        it.id = 4'(open_id);
        it.lo = l;
        it.hi = h;
        send(it);
        if (sb.mark[open_id]) open_id = -1;
    endtask

    task automatic index(int id, logic [15:0] v, bit last);
        t_item it;
        it = noise_item();
        it.op = OP_QUERY;
        it.id = 4'(id);
        it.idx = v;
        it.last = last;
        send(it);
    endtask

    task automatic query(int id, int count, bit extremes);
        int r;
        logic [15:0] v;
        r = id * MAX_DIMS;
        for (int i = 0; i < count; i++) begin
            if (extremes || i >= sb.dims[id] || !sb.mark[id]) v = 16'($urandom);
            else if ($signed(sb.hi[r + i]) >= $signed(sb.lo[r + i]))
                v = 16'($signed(sb.lo[r + i]) + $urandom_range(0, 3));
            else v = sb.lo[r + i];
            index(id, v, i == count - 1);
        end
    endtask

    task automatic define_array(int id, int d, bit wide);
        logic [15:0] l;
        header(id, d, $urandom, wide ? 16'($urandom) : 16'($urandom_range(1, 16)));
        for (int i = 0; i < d; i++) begin
            if (wide) begin
                bound(16'($urandom), 16'($urandom));
            end else begin
                l = 16'($urandom_range(0, 20) - 10);
                bound(l, 16'(l + $urandom_range(0, 5)));
            end
        end
    endtask

    task automatic random_step();
        int id;
        int d;
        int n;
        t_item it;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                id = $urandom_range(0, NUM_ARRAYS - 1);
                d = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_DIMS)
                                                : $urandom_range(1, 3);
                define_array(id, d, $urandom_range(0, 5) == 0);
                n = $urandom_range(1, 3);
                repeat (n) query(id, d, $urandom_range(0, 5) == 0);
            end
            3, 4, 5: begin
                id = $urandom_range(0, NUM_ARRAYS - 1);
                if (sb.mark[id]) query(id, sb.dims[id], 1'b0);
                else query(id, $urandom_range(1, 3), 1'b1);
            end
            6: begin
                id = $urandom_range(0, NUM_ARRAYS - 1);
                n = sb.mark[id] ? sb.dims[id] : 2;
                query(id, n + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 2) + 0,
                      1'b1);
            end
            7: begin
                id = $urandom_range(0, NUM_ARRAYS - 1);
                header(id, $urandom, $urandom, 16'($urandom));
                if (!sb.mark[id] && $urandom_range(0, 1))
                    bound(16'($urandom), 16'($urandom));
            end
            8: begin
                it = noise_item();
                it.op = OP_NONE;
                send(it);
            end
            default: begin
                id = $urandom_range(0, NUM_ARRAYS - 1);
                if (sb.mark[id]) begin
                    it = noise_item();
                    it.op = OP_BOUNDS;
                    it.id = 4'(id);
                    send(it);
                end else begin
                    index(id, 16'($urandom), 1'b1);
                end
            end
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_item it;
        idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        header(0, 0, 32'hFFFF_FFFF, 16'hFFFF);
        bound(16'h8000, 16'h7FFF);
        index(0, 16'h8000, 1'b1);
        index(0, 16'h7FFF, 1'b1);
        header(15, 15, 32'd0, 16'd1);
        for (int i = 0; i < MAX_DIMS; i++)
            bound(16'($signed(-i)), (i == 2) ? 16'($signed(-5)) : 16'($signed(-i) + 1));
        query(15, MAX_DIMS, 1'b1);
        query(15, MAX_DIMS - 2, 1'b0);
        query(15, MAX_DIMS + 1, 1'b0);
        index(5, 16'd3, 1'b1);
        it = noise_item();
        it.op = OP_NONE;
        send(it);
        it = noise_item();
        it.op = OP_BOUNDS;
        it.id = 4'd15;
        send(it);
        header(3, 2, 32'h1000, 16'd0);
        header(4, 1, 32'h2000, 16'd4);
        bound(16'd2, 16'd9);
        index(15, 16'd1, 1'b0);
        index(4, 16'd5, 1'b1);
        drain();

        hold_req = 1'b1;
        repeat (60) random_step();
        drain();
        while (sent < 850) random_step();
        idle_on = 1'b0;
        while (sent < 1000) random_step();
        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/maag_pkg.sv
design/maag_ram.sv
design/multidim_array_address_generator_top.sv
design/maag_checker.sv
dv/testbench.sv
